// ----- hdl/jsu_pkg.sv -----
// Shared types, character codes and decode helpers for the JSON string unescaper.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package jsu_pkg;

  // Item carried on the input channel.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  // Item carried on the result channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       end_of_string;
    logic       decode_error;
  } out_item_t;

  // Decoder phase: plain text, just after a backslash, inside \uXXXX digits.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX   = 2'd2
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LC_N      = 8'h6E;
  localparam logic [7:0] CH_LC_R      = 8'h72;
  localparam logic [7:0] CH_LC_T      = 8'h74;
  localparam logic [7:0] CH_LC_B      = 8'h62;
  localparam logic [7:0] CH_LC_F      = 8'h66;
  localparam logic [7:0] CH_LC_U      = 8'h75;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_QMARK     = 8'h3F;

  localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;

  // Hex digit value in [3:0]; bit 4 set when the byte is a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Mapped byte of a short escape in [7:0]; bit 8 set on a hit.
  function automatic logic [8:0] short_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_QUOTE:     r = {1'b1, CH_QUOTE};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_SLASH:     r = {1'b1, CH_SLASH};
      CH_LC_N:      r = {1'b1, CH_NEWLINE};
      CH_LC_R:      r = {1'b1, CH_CR};
      CH_LC_T:      r = {1'b1, CH_TAB};
      CH_LC_B:      r = {1'b1, CH_BS};
      CH_LC_F:      r = {1'b1, CH_FF};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/jsu_decode.sv -----
// Escape decoder: phase state, hex gathering and one-item result logic.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire jsu_pkg::in_item_t  item,
  output logic                    res_valid,
  output jsu_pkg::out_item_t      res
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        err_r, err_nxt;

  logic [4:0]  hexd;
  logic [8:0]  sesc;
  logic        emit;
  logic [7:0]  val;
  logic        err_fin;
  logic        emit_fin;

  assign hexd = hex_value(item.in_byte);
  assign sesc = short_escape(item.in_byte);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    if (!err_r) begin
      case (phase_r)
        PH_ESC: begin
          if (sesc[8]) begin
            phase_nxt = PH_PLAIN;
          end else if (item.in_byte == CH_LC_U) begin
            phase_nxt = PH_HEX;
            cnt_nxt   = 2'd0;
            acc_nxt   = 16'd0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_HEX: begin
          if (!hexd[4]) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = {acc_r[11:0], hexd[3:0]};
            if (cnt_r == HEX_LAST_DIGIT) begin
              phase_nxt = PH_PLAIN;
              cnt_nxt   = 2'd0;
            end else begin
              cnt_nxt = cnt_r + 2'd1;
            end
          end
        end
        default: begin
          if (item.in_byte == CH_BACKSLASH) begin
            phase_nxt = PH_ESC;
          end
        end
      endcase
    end
  end

  // Emitted byte of this item.
  always_comb begin
    emit = 1'b0;
    val  = 8'd0;
    if (!err_r) begin
      case (phase_r)
        PH_ESC: begin
          emit = sesc[8];
          val  = sesc[7:0];
        end
        PH_HEX: begin
          if (hexd[4] && cnt_r == HEX_LAST_DIGIT) begin
            emit = 1'b1;
            val  = (acc_r[11:3] == 9'd0) ? {acc_r[3:0], hexd[3:0]} : CH_QMARK;
          end
        end
        default: begin
          emit = (item.in_byte != CH_BACKSLASH);
          val  = item.in_byte;
        end
      endcase
    end
  end

  assign err_fin  = err_nxt || (phase_nxt != PH_PLAIN);
  assign emit_fin = item.last_byte ? (emit && !err_fin) : emit;

  assign res_valid         = take && (emit || item.last_byte);
  assign res.out_byte      = emit_fin ? val : 8'd0;
  assign res.out_valid     = emit_fin;
  assign res.end_of_string = item.last_byte;
  assign res.decode_error  = item.last_byte && err_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      cnt_r   <= 2'd0;
      acc_r   <= 16'd0;
      err_r   <= 1'b0;
    end else if (take) begin
      if (item.last_byte) begin
        phase_r <= PH_PLAIN;
        cnt_r   <= 2'd0;
        acc_r   <= 16'd0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last_byte |=> phase_r == PH_PLAIN && !err_r && cnt_r == 2'd0)
    else $error("decoder did not restart after the final byte");

  a_error_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.decode_error |-> res.end_of_string && !res.out_valid)
    else $error("error flag outside a clean end result");

  a_no_emit_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && res_valid |-> !res.out_valid && res.end_of_string)
    else $error("byte emitted after a decode error");

endmodule

`default_nettype wire

// ----- hdl/jsu_out_buf.sv -----
// Two-entry result buffer (head plus skid) between decoder and result port.
// Depends on jsu_pkg.
`default_nettype none

module jsu_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire jsu_pkg::out_item_t  push_item,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jsu_pkg::out_item_t       out_data
);
  import jsu_pkg::*;

  out_item_t head_r, skid_r;
  logic      v0_r, v1_r;
  logic      pop;

  assign pop       = v0_r && !out_stall;
  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (pop) begin
      if (v1_r) begin
        v1_r <= push;
      end else begin
        v0_r <= push;
      end
    end else if (push) begin
      if (v0_r) begin
        v1_r <= 1'b1;
      end else begin
        v0_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= push_item;
        end
      end else if (push) begin
        head_r <= push_item;
      end
    end else if (push) begin
      if (v0_r) begin
        skid_r <= push_item;
      end else begin
        head_r <= push_item;
      end
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !v1_r)
    else $error("item pushed into a full result buffer");

endmodule

`default_nettype wire

// ----- hdl/json_string_unescape_core.sv -----
// Top level of the JSON string unescaper: decoder plus two-entry result buffer.
// Depends on jsu_pkg, jsu_decode and jsu_out_buf.
//
// Feed the raw escaped body of a JSON string, one byte per item, with
// last_byte set on the final byte. Plain bytes come out unchanged; the short
// escapes (\" \\ \/ \n \r \t \b \f) come out as their mapped byte, and \uXXXX
// comes out as the code point when it is below 0x80 and as '?' otherwise.
// Bytes that open or continue an escape produce no result. The final byte
// always produces one result with end_of_string set; decode_error on it tells
// whether an unknown escape, a bad hex digit or an unfinished escape was seen,
// and after an error no further bytes are emitted for that string. One item is
// taken per clock while in_stall is low: the decode is combinational logic
// from the phase registers to the result buffer, and the result buffer has a
// skid entry, so in_stall rises only when two results wait and the consumer
// stalls. A result is registered in the buffer before it reaches the output.
`default_nettype none

module json_string_unescape_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jsu_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jsu_pkg::out_item_t       out_data
);
  import jsu_pkg::*;

  logic      take;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  // Accept whenever the skid entry is free; stall comes straight from a register.
  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  jsu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
